// ----- rtl/chmlp_pkg.sv -----
// ----------------------------------------------------------------------------
// chmlp_pkg
// Shared types and constants of the counting hash map with linear probing.
// ----------------------------------------------------------------------------
package chmlp_pkg;

    // Operation codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_FIND   = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    // Multiplicative hash constant and its 32-bit halves
    localparam logic [63:0] HASH_MUL    = 64'd12345678911234567891;
    localparam logic [31:0] HASH_MUL_LO = HASH_MUL[31:0];
    localparam logic [31:0] HASH_MUL_HI = HASH_MUL[63:32];

    // Saturation value of a slot count
    localparam logic [30:0] COUNT_MAX = 31'h7FFF_FFFF;

    // Queue between front and back
    localparam int FIFO_DEPTH    = 2;
    localparam int FIFO_PTR_BITS = 1;

    // Request and result payloads
    typedef struct packed {
        logic [1:0]  opcode;
        logic [63:0] key;
    } req_t;

    typedef struct packed {
        logic [30:0] count;
        logic        status;
    } res_t;

    // One table slot as stored in memory
    typedef struct packed {
        logic        valid;
        logic [63:0] key;
        logic [30:0] count;
    } slot_t;

    // Queue status seen by the producer and the consumer
    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    typedef enum logic [2:0] {
        FR_IDLE,
        FR_MUL_LO,
        FR_MUL_X1,
        FR_MUL_X2,
        FR_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        BK_INIT,
        BK_IDLE,
        BK_PROBE,
        BK_CLEAR,
        BK_FINISH
    } back_state_t;

endpackage

// ----- rtl/chmlp_front.sv -----
// ----------------------------------------------------------------------------
// chmlp_front
// Accepts requests and computes the home slot with one shared 32x32
// multiplier in states FR_MUL_LO, FR_MUL_X1 and FR_MUL_X2, then pushes request and home slot to the queue.
// ----------------------------------------------------------------------------
module chmlp_front
    import chmlp_pkg::*;
#(
    parameter int INDEX_BITS = 10
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  req_t                  req_data,
    input  fifo_stat_t            fifo_stat,
    output logic                  push,
    output req_t                  push_req,
    output logic [INDEX_BITS-1:0] push_home
);

    front_state_t state_reg;
    front_state_t state_next;
    req_t         req_reg;
    logic [31:0]  prod_reg;
    logic [31:0]  cross_reg;
    logic [31:0]  mul_a;
    logic [31:0]  mul_b;
    logic [63:0]  mul_p;
    logic [31:0]  hash_hi;
    logic         take;

    // Select multiplier operands for each partial product
    always_comb
    begin
        unique case (state_reg)
            FR_MUL_LO:
            begin
                mul_a = req_reg.key[31:0];
                mul_b = HASH_MUL_LO;
            end
            FR_MUL_X1:
            begin
                mul_a = req_reg.key[63:32];
                mul_b = HASH_MUL_LO;
            end
            FR_MUL_X2:
            begin
                mul_a = req_reg.key[31:0];
                mul_b = HASH_MUL_HI;
            end
            default:
            begin
                mul_a = req_reg.key[31:0];
                mul_b = HASH_MUL_LO;
            end
        endcase
    end

    assign mul_p   = 64'(mul_a) * 64'(mul_b);
    assign hash_hi = prod_reg + cross_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FR_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = FR_MUL_LO;
                end
            end
            FR_MUL_LO: state_next = FR_MUL_X1;
            FR_MUL_X1: state_next = FR_MUL_X2;
            FR_MUL_X2: state_next = FR_PUSH;
            FR_PUSH:
            begin
                if (!fifo_stat.full)
                begin
                    state_next = req_valid ? FR_MUL_LO : FR_IDLE;
                end
            end
            default: state_next = FR_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        req_stall = 1'b1;
        push      = 1'b0;
        unique case (state_reg)
            FR_IDLE:
            begin
                req_stall = 1'b0;
            end
            FR_PUSH:
            begin
                push      = !fifo_stat.full;
                req_stall = fifo_stat.full;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

    assign take      = req_valid && !req_stall;
    assign push_req  = req_reg;
    assign push_home = hash_hi[31 -: INDEX_BITS];

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FR_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Capture the request and accumulate partial products
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            req_reg <= req_data;
        end
        if (state_reg == FR_MUL_LO)
        begin
            prod_reg <= mul_p[63:32];
        end
        if (state_reg == FR_MUL_X1)
        begin
            cross_reg <= mul_p[31:0];
        end
        if (state_reg == FR_MUL_X2)
        begin
            cross_reg <= cross_reg + mul_p[31:0];
        end
    end

endmodule

// ----- rtl/chmlp_fifo.sv -----
// ----------------------------------------------------------------------------
// chmlp_fifo
// Two-entry queue that decouples the hashing front from the probing back.
// ----------------------------------------------------------------------------
module chmlp_fifo
    import chmlp_pkg::*;
#(
    parameter int WIDTH = 76
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head_data,
    output fifo_stat_t       stat
);

    logic [WIDTH-1:0]         entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] wr_ptr_reg;
    logic [FIFO_PTR_BITS-1:0] rd_ptr_reg;
    logic [FIFO_PTR_BITS:0]   fill_reg;

    assign stat.full  = (fill_reg == (FIFO_PTR_BITS+1)'(FIFO_DEPTH));
    assign stat.empty = (fill_reg == '0);
    assign head_data  = entry_reg[rd_ptr_reg];

    // Advance pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- rtl/chmlp_back.sv -----
// ----------------------------------------------------------------------------
// chmlp_back
// Executes queued requests against the slot memory: probes one slot a cycle,
// updates counts, sweeps the table on clear and after reset, and holds the
// result in an output register.
// ----------------------------------------------------------------------------
module chmlp_back
    import chmlp_pkg::*;
#(
    parameter int INDEX_BITS = 10
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  fifo_stat_t            fifo_stat,
    input  req_t                  head_req,
    input  logic [INDEX_BITS-1:0] head_home,
    output logic                  pop,
    output logic                  res_valid,
    input  logic                  res_stall,
    output res_t                  res_data
);

    localparam int TABLE_SIZE = 1 << INDEX_BITS;

    slot_t                 mem [TABLE_SIZE];
    slot_t                 rdata_reg;

    back_state_t           state_reg;
    back_state_t           state_next;
    logic [INDEX_BITS-1:0] pos_reg;
    logic [INDEX_BITS-1:0] probe_reg;
    logic [INDEX_BITS-1:0] sweep_reg;
    req_t                  op_reg;
    logic                  res_valid_reg;
    res_t                  res_reg;

    logic                  out_free;
    logic                  hit;
    logic                  empty;
    logic                  last_probe;
    logic                  done;
    logic                  sweep_last;
    logic                  load;
    res_t                  load_res;
    logic                  we;
    logic [INDEX_BITS-1:0] waddr;
    slot_t                 wdata;
    logic [INDEX_BITS-1:0] raddr;
    logic                  step;
    logic [30:0]           count_inc;

    assign out_free   = !res_valid_reg || !res_stall;
    assign hit        = rdata_reg.valid && (rdata_reg.key == op_reg.key);
    assign empty      = !rdata_reg.valid;
    assign last_probe = (probe_reg == {INDEX_BITS{1'b1}});
    assign done       = hit || empty || last_probe;
    assign sweep_last = (sweep_reg == {INDEX_BITS{1'b1}});
    assign count_inc  = (rdata_reg.count < COUNT_MAX) ? rdata_reg.count + 31'd1
                                                      : rdata_reg.count;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_INIT:
            begin
                if (sweep_last)
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_IDLE:
            begin
                if (!fifo_stat.empty)
                begin
                    case (head_req.opcode) inside
                        OP_INSERT, OP_FIND: state_next = BK_PROBE;
                        OP_CLEAR:           state_next = BK_CLEAR;
                        default:            state_next = BK_FINISH;
                    endcase
                end
            end
            BK_PROBE:
            begin
                if (done && out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_CLEAR:
            begin
                if (sweep_last)
                begin
                    state_next = BK_FINISH;
                end
            end
            BK_FINISH:
            begin
                if (out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // Outputs: memory access, queue pop and result load
    always_comb
    begin
        pop      = 1'b0;
        load     = 1'b0;
        load_res = '0;
        we       = 1'b0;
        waddr    = sweep_reg;
        wdata    = '0;
        raddr    = pos_reg;
        step     = 1'b0;
        unique case (state_reg)
            BK_INIT, BK_CLEAR:
            begin
                we    = 1'b1;
                waddr = sweep_reg;
                wdata = '0;
            end
            BK_IDLE:
            begin
                pop   = !fifo_stat.empty;
                raddr = head_home;
            end
            BK_PROBE:
            begin
                if (!done)
                begin
                    step  = 1'b1;
                    raddr = pos_reg + 1'b1;
                end
                else if (out_free)
                begin
                    load  = 1'b1;
                    waddr = pos_reg;
                    if (op_reg.opcode == OP_INSERT)
                    begin
                        if (hit)
                        begin
                            we             = 1'b1;
                            wdata          = rdata_reg;
                            wdata.count    = count_inc;
                            load_res.count = count_inc;
                        end
                        else if (empty)
                        begin
                            we             = 1'b1;
                            wdata.valid    = 1'b1;
                            wdata.key      = op_reg.key;
                            wdata.count    = 31'd1;
                            load_res.count = 31'd1;
                        end
                        else
                        begin
                            load_res.status = 1'b1;
                        end
                    end
                    else if (hit)
                    begin
                        load_res.count = rdata_reg.count;
                    end
                end
            end
            BK_FINISH:
            begin
                load = out_free;
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    // Hold state, pointers and the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_INIT;
            sweep_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == BK_INIT || state_reg == BK_CLEAR)
            begin
                sweep_reg <= sweep_reg + 1'b1;
            end
            if (load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Capture the popped request and advance the probe
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            op_reg    <= head_req;
            pos_reg   <= head_home;
            probe_reg <= '0;
        end
        else if (step)
        begin
            pos_reg   <= pos_reg + 1'b1;
            probe_reg <= probe_reg + 1'b1;
        end
        if (load)
        begin
            res_reg <= load_res;
        end
    end

    // Slot memory with registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

endmodule

// ----- rtl/counting_hash_map_linear_probe_unit.sv -----
// Flow: the front registers the request, forms the hash with one 32x32
// multiplier in states FR_MUL_LO, FR_MUL_X1 and FR_MUL_X2 and pushes it in
// FR_PUSH; the back pops it, probes one slot per cycle and registers the
// result. The front takes the next request in FR_IDLE, or in FR_PUSH when
// the queue has room. Clear sweeps every slot empty, one slot per cycle.
// Reset: the back sweeps all 2^INDEX_BITS slots empty before it executes
// the first request; requests are still accepted into the queue meanwhile.
// ----------------------------------------------------------------------------
// counting_hash_map_linear_probe_unit
// Counting multiset over an open-addressed table with linear probing.
// ----------------------------------------------------------------------------
module counting_hash_map_linear_probe_unit
    import chmlp_pkg::*;
#(
    parameter int INDEX_BITS = 10
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req_data,
    output logic res_valid,
    input  logic res_stall,
    output res_t res_data
);

    localparam int QW = INDEX_BITS + $bits(req_t);

    fifo_stat_t            fifo_stat;
    logic                  push;
    req_t                  push_req;
    logic [INDEX_BITS-1:0] push_home;
    logic                  pop;
    logic [QW-1:0]         head_data;
    req_t                  head_req;
    logic [INDEX_BITS-1:0] head_home;

    // Hash front
    chmlp_front #(
        .INDEX_BITS (INDEX_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .fifo_stat (fifo_stat),
        .push      (push),
        .push_req  (push_req),
        .push_home (push_home)
    );

    // Queue between front and back
    chmlp_fifo #(
        .WIDTH (QW)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_home, push_req}),
        .pop       (pop),
        .head_data (head_data),
        .stat      (fifo_stat)
    );

    assign head_home = head_data[QW-1 -: INDEX_BITS];
    assign head_req  = head_data[$bits(req_t)-1:0];

    // Probing back
    chmlp_back #(
        .INDEX_BITS (INDEX_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .fifo_stat (fifo_stat),
        .head_req  (head_req),
        .head_home (head_home),
        .pop       (pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

endmodule
